### rtl/ipv4_lpm_multibit_trie_defines.svh
// assertion macros for the route table block
`ifndef IPV4_LPM_MULTIBIT_TRIE_DEFINES_SVH
`define IPV4_LPM_MULTIBIT_TRIE_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define LPM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked at every rising clock edge outside reset
`define LPM_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

### rtl/lpm_pkg.sv
// types and constants of the ipv4 longest prefix match route table
package lpm_pkg;

    localparam int NODE_COUNT = 256;
    localparam int PORT_BITS  = 4;
    localparam int NODE_BITS  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int NODE_SIZE  = 16;
    localparam int LAST_LEVEL = 6;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_ADD    = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_POOL_FULL = 1'b1;

    typedef struct packed {
        logic       func;
        logic [31:0] address;
        logic [5:0] prefix_len;
        logic [3:0] route_port;
    } req_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] out_port;
        logic       status;
    } rsp_t;

    typedef struct packed {
        logic                 has_port;
        logic                 has_child;
        logic [3:0]           lpm;
        logic [PORT_BITS-1:0] port;
        logic [NODE_BITS-1:0] child;
    } entry_t;

endpackage

### rtl/ipv4_lpm_multibit_trie.sv
// ipv4 longest prefix match route table, multibit trie walked by a sequencer
// lookup: one trie level per cycle
// add: levels step through S_WRD, S_WCHK, S_NEXT; a taken node is swept clear in S_CLR
// add: expanded entries get read-modify-write (S_SRD, S_SWR), up to 256 at the top table
// one request at a time; a new request is taken once the response has been taken
// reset clears top table valid bits and the free node counter at once, no clearing pass
`include "ipv4_lpm_multibit_trie_defines.svh"

module ipv4_lpm_multibit_trie (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lpm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lpm_pkg::rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE, S_LK, S_WRD, S_WCHK, S_CLR, S_NEXT, S_SRD, S_SWR
    } state_t;

    localparam int NAW = lpm_pkg::NODE_BITS + 4;
    localparam logic [lpm_pkg::NODE_BITS:0] POOL_END =
        (lpm_pkg::NODE_BITS+1)'(lpm_pkg::NODE_COUNT);

    state_t state_reg, state_next;
    logic          out_valid_reg, out_valid_next;
    lpm_pkg::rsp_t out_reg, out_next;
    logic [31:0]   addr_reg, addr_next;
    logic [lpm_pkg::PORT_BITS-1:0] port_reg, port_next;
    logic [2:0]    lvl_reg, lvl_next;
    logic [2:0]    last_reg, last_next;
    logic [3:0]    rem_reg, rem_next;
    logic [lpm_pkg::NODE_BITS-1:0] cur_reg, cur_next;
    logic [lpm_pkg::NODE_BITS:0]   free_reg, free_next;
    logic          hit_reg, hit_next;
    logic [lpm_pkg::PORT_BITS-1:0] hport_reg, hport_next;
    logic          top_sp_reg, top_sp_next;
    logic [7:0]    base_reg, base_next;
    logic [8:0]    cnt_reg, cnt_next;
    logic [8:0]    span_reg, span_next;

    lpm_pkg::entry_t top_mem [256];
    lpm_pkg::entry_t node_mem [lpm_pkg::NODE_COUNT * lpm_pkg::NODE_SIZE];
    logic [255:0]    top_vld_reg;
    lpm_pkg::entry_t top_rd_reg, node_rd_reg;
    logic            top_rv_reg;

    logic [7:0]      top_ra, top_wa;
    logic [NAW-1:0]  node_ra, node_wa;
    logic            top_we, node_we;
    lpm_pkg::entry_t top_wd, node_wd;

    lpm_pkg::entry_t ent, upd;
    logic [2:0]      k;
    logic [4:0]      shamt;
    logic [31:0]     shifted;
    logic [3:0]      nib;
    logic [5:0]      len_sat;
    logic [4:0]      lenm;
    logic [2:0]      levels;
    logic [4:0]      rem_calc;
    logic [8:0]      tspan, tmask, nspan, nmask;
    logic [7:0]      rp8, op8;
    logic [8:0]      cnt_inc;

    assign req_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // current entry: top table entries without a valid bit read as empty
    assign ent = (lvl_reg == 3'd0) ? (top_rv_reg ? top_rd_reg : '0) : node_rd_reg;

    // shared shift unit picks the stride nibble for level k
    assign k       = (state_reg == S_WRD || state_reg == S_WCHK) ? lvl_reg : lvl_reg + 3'd1;
    assign shamt   = 5'd24 - {k, 2'b00};
    assign shifted = addr_reg >> shamt;
    assign nib     = shifted[3:0];

    assign len_sat  = (req.prefix_len > 6'd32) ? 6'd32 : req.prefix_len;
    assign lenm     = 5'(len_sat - 6'd8);
    assign levels   = 3'((6'(lenm) + 6'd3) >> 2);
    assign rem_calc = lenm - {levels - 3'd1, 2'b00};
    assign tspan    = 9'd1 << (4'd8 - len_sat[3:0]);
    assign tmask    = ~(tspan - 9'd1);
    assign nspan    = 9'd1 << (3'd4 - rem_reg[2:0]);
    assign nmask    = ~(nspan - 9'd1);
    assign rp8      = {4'b0000, req.route_port};
    assign op8      = 8'(hport_reg);
    assign cnt_inc  = cnt_reg + 9'd1;

    always_comb
    begin
        upd = ent;
        if (!ent.has_port || ent.lpm < rem_reg)
        begin
            upd.has_port = 1'b1;
            upd.lpm      = rem_reg;
            upd.port     = port_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        addr_next      = addr_reg;
        port_next      = port_reg;
        lvl_next       = lvl_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        cur_next       = cur_reg;
        free_next      = free_reg;
        hit_next       = hit_reg;
        hport_next     = hport_reg;
        top_sp_next    = top_sp_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        span_next      = span_reg;
        top_ra  = addr_reg[31:24];
        top_wa  = addr_reg[31:24];
        top_we  = 1'b0;
        top_wd  = upd;
        node_ra = {cur_reg, nib};
        node_wa = {cur_reg, nib};
        node_we = 1'b0;
        node_wd = upd;

        if (out_valid_reg && rsp_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                top_ra = req.address[31:24];
                if (req_valid && req_ready)
                begin
                    addr_next  = req.address;
                    port_next  = rp8[lpm_pkg::PORT_BITS-1:0];
                    lvl_next   = 3'd0;
                    hit_next   = 1'b0;
                    hport_next = '0;
                    cnt_next   = '0;
                    if (req.func == lpm_pkg::FUNC_LOOKUP)
                        state_next = S_LK;
                    else if (len_sat <= 6'd8)
                    begin
                        top_sp_next = 1'b1;
                        span_next   = tspan;
                        base_next   = req.address[31:24] & tmask[7:0];
                        rem_next    = len_sat[3:0];
                        state_next  = S_SRD;
                    end
                    else
                    begin
                        last_next  = levels;
                        rem_next   = rem_calc[3:0];
                        state_next = S_WRD;
                    end
                end
            end
            S_LK:
            begin
                node_ra = {ent.child, nib};
                if (ent.has_port)
                begin
                    hit_next   = 1'b1;
                    hport_next = ent.port;
                end
                if (ent.has_child && lvl_reg != 3'(lpm_pkg::LAST_LEVEL))
                    lvl_next = lvl_reg + 3'd1;
                else
                begin
                    out_next.hit      = hit_reg | ent.has_port;
                    out_next.out_port = ent.has_port ? 4'(8'(ent.port))
                                                     : (hit_reg ? op8[3:0] : 4'd0);
                    out_next.status   = lpm_pkg::STATUS_OK;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_WRD:
                state_next = S_WCHK;
            S_WCHK:
            begin
                if (ent.has_child)
                begin
                    cur_next   = ent.child;
                    state_next = S_NEXT;
                end
                else if (free_reg >= (lpm_pkg::NODE_BITS+1)'(lpm_pkg::NODE_COUNT))
                begin
                    out_next.hit      = 1'b0;
                    out_next.out_port = 4'd0;
                    out_next.status   = lpm_pkg::STATUS_POOL_FULL;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    top_wd.has_child  = 1'b1;
                    top_wd.child      = free_reg[lpm_pkg::NODE_BITS-1:0];
                    top_wd.has_port   = ent.has_port;
                    top_wd.lpm        = ent.lpm;
                    top_wd.port       = ent.port;
                    node_wd           = top_wd;
                    top_we            = (lvl_reg == 3'd0);
                    node_we           = (lvl_reg != 3'd0);
                    cur_next          = free_reg[lpm_pkg::NODE_BITS-1:0];
                    free_next         = free_reg + (lpm_pkg::NODE_BITS+1)'(1);
                    cnt_next          = '0;
                    state_next        = S_CLR;
                end
            end
            S_CLR:
            begin
                // new node is zeroed one entry a cycle
                node_wa  = {cur_reg, cnt_reg[3:0]};
                node_wd  = '0;
                node_we  = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_reg[3:0] == 4'hf)
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (lvl_reg + 3'd1 == last_reg)
                begin
                    lvl_next    = lvl_reg + 3'd1;
                    top_sp_next = 1'b0;
                    span_next   = nspan;
                    base_next   = {4'b0000, nib & nmask[3:0]};
                    cnt_next    = '0;
                    state_next  = S_SRD;
                end
                else
                begin
                    lvl_next   = lvl_reg + 3'd1;
                    state_next = S_WRD;
                end
            end
            S_SRD:
            begin
                top_ra     = base_reg | cnt_reg[7:0];
                node_ra    = {cur_reg, base_reg[3:0] | cnt_reg[3:0]};
                state_next = S_SWR;
            end
            S_SWR:
            begin
                top_wa   = base_reg | cnt_reg[7:0];
                node_wa  = {cur_reg, base_reg[3:0] | cnt_reg[3:0]};
                top_we   = top_sp_reg;
                node_we  = !top_sp_reg;
                cnt_next = cnt_inc;
                if (cnt_inc == span_reg)
                begin
                    out_next.hit      = 1'b0;
                    out_next.out_port = 4'd0;
                    out_next.status   = lpm_pkg::STATUS_OK;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                    state_next = S_SRD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            free_reg      <= '0;
            top_vld_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            free_reg      <= free_next;
            if (top_we)
                top_vld_reg[top_wa] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        port_reg   <= port_next;
        lvl_reg    <= lvl_next;
        last_reg   <= last_next;
        rem_reg    <= rem_next;
        cur_reg    <= cur_next;
        hit_reg    <= hit_next;
        hport_reg  <= hport_next;
        top_sp_reg <= top_sp_next;
        base_reg   <= base_next;
        cnt_reg    <= cnt_next;
        span_reg   <= span_next;
        top_rv_reg <= top_vld_reg[top_ra];
    end

    always_ff @(posedge clk)
    begin
        if (top_we)
            top_mem[top_wa] <= top_wd;
        top_rd_reg <= top_mem[top_ra];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_wa] <= node_wd;
        node_rd_reg <= node_mem[node_ra];
    end

    `LPM_ASSERT(a_free_bound, free_reg <= POOL_END, "free node count past pool")
    `LPM_ASSERT_IMP(a_rsp_from_busy, $rose(out_valid_reg), $past(state_reg) != S_IDLE, "idle rsp")
    `LPM_ASSERT_IMP(a_fail_no_hit, out_valid_reg && out_reg.status, !out_reg.hit, "failed add hit")

endmodule
